@@ rtl/amicable_pair_check_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the amicable pair check unit
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AMICABLE_PAIR_CHECK_UNIT_ASSERT_SVH
`define AMICABLE_PAIR_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define APC_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`define APC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define APC_ASSERT_SAME(label, pre, post, msg)
`define APC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ rtl/apc_pkg.sv @@
// ----------------------------------------------------------------------------
// apc_pkg
// Shared widths, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apc_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int SUM_WIDTH   = VALUE_WIDTH + 2;
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int IN_DATA_W   = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + 2 * SUM_WIDTH;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_SHIFT,
    ST_CHECK,
    ST_SWITCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic shift_step;
    logic accumulate;
    logic switch_op;
    logic load_out;
  } apc_cmd_t;

  typedef struct packed {
    logic div_over;
    logic bit_last;
    logic second_op;
  } apc_stat_t;

endpackage

@@ rtl/apc_ctrl.sv @@
// ----------------------------------------------------------------------------
// apc_ctrl
// Sequencer: walks trial divisors for both values and hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  input  apc_pkg::apc_stat_t stat_i,
  output apc_pkg::apc_cmd_t  cmd_o
);
  import apc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_TEST;
      end
      ST_TEST: begin
        if (!stat_i.div_over)      state_d = ST_SHIFT;
        else if (stat_i.second_op) state_d = ST_DONE;
        else                       state_d = ST_SWITCH;
      end
      ST_SHIFT: begin
        if (stat_i.bit_last) state_d = ST_CHECK;
      end
      ST_CHECK:  state_d = ST_TEST;
      ST_SWITCH: state_d = ST_TEST;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_TEST:   cmd_o.start_div  = !stat_i.div_over;
      ST_SHIFT:  cmd_o.shift_step = 1'b1;
      ST_CHECK:  cmd_o.accumulate = 1'b1;
      ST_SWITCH: cmd_o.switch_op  = 1'b1;
      ST_DONE:   cmd_o.load_out   = out_free_i;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/apc_dp.sv @@
// ----------------------------------------------------------------------------
// apc_dp
// Operand registers, bit-serial restoring remainder and divisor sum accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  apc_pkg::apc_cmd_t                cmd_i,
  output apc_pkg::apc_stat_t               stat_o,
  input  logic [apc_pkg::VALUE_WIDTH-1:0]  first_value_i,
  input  logic [apc_pkg::VALUE_WIDTH-1:0]  second_value_i,
  output logic                             is_amicable_o,
  output logic [apc_pkg::SUM_WIDTH-1:0]    first_sum_o,
  output logic [apc_pkg::SUM_WIDTH-1:0]    second_sum_o
);
  import apc_pkg::*;

  logic [VALUE_WIDTH-1:0] val_a_q, val_b_q;
  logic [VALUE_WIDTH-1:0] trial_q, rem_q;
  logic [IDX_W-1:0]       idx_q;
  logic [SUM_WIDTH-1:0]   acc_a_q, acc_b_q;
  logic                   sel_q;

  logic [VALUE_WIDTH-1:0] cur_val;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH-1:0] rem_next;

  assign cur_val = sel_q ? val_b_q : val_a_q;

  // shift in the next dividend bit, subtract the divisor when it fits
  assign rem_sh = {rem_q, cur_val[idx_q]};
  always_comb begin
    if (rem_sh >= {1'b0, trial_q}) begin
      rem_next = VALUE_WIDTH'(rem_sh - {1'b0, trial_q});
    end else begin
      rem_next = rem_sh[VALUE_WIDTH-1:0];
    end
  end

  assign stat_o.div_over  = trial_q > (cur_val >> 1);
  assign stat_o.bit_last  = (idx_q == '0);
  assign stat_o.second_op = sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      sel_q <= 1'b0;
    end else if (cmd_i.switch_op) begin
      sel_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      val_a_q <= first_value_i;
      val_b_q <= second_value_i;
      acc_a_q <= '0;
      acc_b_q <= '0;
      trial_q <= VALUE_WIDTH'(1);
    end
    if (cmd_i.switch_op) begin
      trial_q <= VALUE_WIDTH'(1);
    end
    if (cmd_i.start_div) begin
      rem_q <= '0;
      idx_q <= IDX_W'(VALUE_WIDTH - 1);
    end
    if (cmd_i.shift_step) begin
      rem_q <= rem_next;
      idx_q <= idx_q - IDX_W'(1);
    end
    if (cmd_i.accumulate) begin
      trial_q <= trial_q + VALUE_WIDTH'(1);
      if (rem_q == '0) begin
        if (sel_q) acc_b_q <= acc_b_q + SUM_WIDTH'(trial_q);
        else       acc_a_q <= acc_a_q + SUM_WIDTH'(trial_q);
      end
    end
  end

  assign is_amicable_o = (acc_a_q == SUM_WIDTH'(val_b_q)) &&
                         (acc_b_q == SUM_WIDTH'(val_a_q));
  assign first_sum_o   = acc_a_q;
  assign second_sum_o  = acc_b_q;

endmodule

@@ rtl/amicable_pair_check_unit.sv @@
// Each trial divisor runs test, a 16-step bit-serial remainder and accumulate;
//   divisors 1 to floor(a/2) and 1 to floor(b/2) are tried, with a and b the two
//   values. A new input word is taken only in idle, after the result has entered
//   the output register, which waits while a pending word is held.
// Reset: asynchronous, active low; clears controller state and output valid.
// ----------------------------------------------------------------------------
// amicable_pair_check_unit
// Proper divisor sums of two values by trial division, with amicable flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "amicable_pair_check_unit_assert.svh"

module amicable_pair_check_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] first_value, [31:16] second_value
  input  logic [apc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] is_amicable, [18:1] first_divisor_sum, [36:19] second_divisor_sum, rest zero
  output logic [apc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import apc_pkg::*;

  apc_cmd_t  cmd;
  apc_stat_t stat;

  logic                 out_free;
  logic                 flag;
  logic [SUM_WIDTH-1:0] sum_a, sum_b;

  logic                 out_valid_q;
  logic [OUT_BITS-1:0]  out_data_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  apc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  apc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .first_value_i  (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .second_value_i (s_axis_tdata_i[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .is_amicable_o  (flag),
    .first_sum_o    (sum_a),
    .second_sum_o   (sum_b)
  );

  // hold the result word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      out_data_q <= {sum_b, sum_a, flag};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_data_q);

  `APC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o,
                   !s_axis_tready_o, "input accepted while busy")
  `APC_ASSERT_SAME(a_load_into_free, cmd.load_out, !out_valid_q || m_axis_tready_i,
                   "result overwrote a pending word")
  `APC_ASSERT_SAME(a_no_accept_in_div, cmd.shift_step, !s_axis_tready_o,
                   "ready raised during division")

endmodule
